[hdl/cst_pkg.sv]
// Package with the shared types and constants of the counting semaphore table.
package cst_pkg;

    localparam int ACT_W   = 2;
    localparam int ID_W    = 4;
    localparam int COUNT_W = 16;
    localparam int ID_SPAN = 1 << ID_W;

    localparam logic [ACT_W-1:0] ACT_CREATE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_P      = 2'd2;
    localparam logic [ACT_W-1:0] ACT_V      = 2'd3;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_NO_FREE = 1'b1;

    typedef logic signed [COUNT_W-1:0] t_count;

    localparam t_count COUNT_MAX = 16'sh7FFF;
    localparam t_count COUNT_MIN = 16'sh8000;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

[hdl/cst_ctrl.sv]
// Controller state machine that sequences the load and execute steps of one operation.
module cst_ctrl
    import cst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_done,
    output t_dp_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_done;
    logic n_done;

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        o_cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_done     = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign busy   = (r_state == ST_EXEC);
    assign o_done = r_done;

endmodule

[hdl/cst_datapath.sv]
// Datapath holding the semaphore stores, the free-entry search and the count update.
module cst_datapath
    import cst_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [ID_W-1:0]    i_entry_id,
    input  t_count             i_initial_count,
    output logic               o_status,
    output logic [ID_W-1:0]    o_created_id,
    output logic               o_must_wait,
    output logic               o_wake_one
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ACT_W-1:0] r_act;
    logic [ID_W-1:0]  r_id;
    t_count           r_init;

    logic [DEPTH-1:0] r_alloc;
    t_count           r_count [DEPTH];

    logic             r_status;
    logic [ID_W-1:0]  r_cid;
    logic             r_wait;
    logic             r_wake;

    logic             found;
    logic [IDX_W-1:0] free_idx;
    logic             in_range;
    logic [IDX_W-1:0] sel;
    t_count           cur;
    t_count           dec;
    t_count           inc;
    logic             wr_count;
    t_count           wr_value;
    logic             set_alloc;
    logic             clr_alloc;
    logic             n_status;
    logic [ID_W-1:0]  n_cid;
    logic             n_wait;
    logic             n_wake;

    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (!r_alloc[k]) begin
                found    = 1'b1;
                free_idx = IDX_W'(k);
            end
        end
    end

    assign in_range = (32'(r_id) < DEPTH);
    assign sel      = (r_act == ACT_CREATE) ? free_idx : r_id[IDX_W-1:0];
    assign cur      = r_count[sel];
    assign dec      = (cur != COUNT_MIN) ? cur - 16'sd1 : cur;
    assign inc      = (cur != COUNT_MAX) ? cur + 16'sd1 : cur;

    always_comb begin
        wr_count  = 1'b0;
        wr_value  = cur;
        set_alloc = 1'b0;
        clr_alloc = 1'b0;
        n_status  = STATUS_DONE;
        n_cid     = '0;
        n_wait    = 1'b0;
        n_wake    = 1'b0;
        unique case (r_act)
            ACT_CREATE: begin
                if (found) begin
                    set_alloc = 1'b1;
                    wr_count  = 1'b1;
                    wr_value  = r_init;
                    n_cid     = ID_W'(free_idx);
                end else begin
                    n_status = STATUS_NO_FREE;
                end
            end
            ACT_FREE: begin
                if (in_range && r_alloc[sel] && (cur > 16'sd0)) begin
                    clr_alloc = 1'b1;
                end
            end
            ACT_P: begin
                if (in_range) begin
                    wr_count = 1'b1;
                    wr_value = dec;
                    n_wait   = (dec < 16'sd0);
                end
            end
            ACT_V: begin
                if (in_range) begin
                    wr_count = 1'b1;
                    wr_value = inc;
                    n_wake   = (inc < 16'sd1);
                end
            end
            default: begin
                wr_count = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_action;
            r_id   <= i_entry_id;
            r_init <= i_initial_count;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_cid    <= n_cid;
            r_wait   <= n_wait;
            r_wake   <= n_wake;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
            for (int k = 0; k < DEPTH; k++) begin
                r_count[k] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (set_alloc) begin
                r_alloc[sel] <= 1'b1;
            end
            if (clr_alloc) begin
                r_alloc[sel] <= 1'b0;
            end
            if (wr_count) begin
                r_count[sel] <= wr_value;
            end
        end
    end

    assign o_status     = r_status;
    assign o_created_id = r_cid;
    assign o_must_wait  = r_wait;
    assign o_wake_one   = r_wake;

endmodule

[hdl/counting_semaphore_table_top.sv]
// Top level of the counting semaphore table: controller, datapath and checks.
//
//   Channel   Direction  Transfer when      Signals
//   command   in         start && !busy     i_action, i_entry_id, i_initial_count
//   result    out        o_done             o_status, o_created_id, o_must_wait, o_wake_one
//
// Each operation has a load step that captures the command and an execute step that
// reads, updates and writes back the addressed entry in the datapath registers.
// The result is shown for one cycle after that, while the next command may be taken.
// Reset is synchronous and active low; it clears both stores and the controller.
// The receiver cannot stall, so results never wait.
module counting_semaphore_table_top
    import cst_pkg::*;
#(
    parameter int SEM_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [ID_W-1:0]    i_entry_id,
    input  t_count             i_initial_count,
    output logic               o_done,
    output logic               o_status,
    output logic [ID_W-1:0]    o_created_id,
    output logic               o_must_wait,
    output logic               o_wake_one
);

    localparam int DEPTH = (SEM_ENTRIES < ID_SPAN) ? SEM_ENTRIES : ID_SPAN;

    t_dp_cmd cmd;

    cst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    cst_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_action        (i_action),
        .i_entry_id      (i_entry_id),
        .i_initial_count (i_initial_count),
        .o_status        (o_status),
        .o_created_id    (o_created_id),
        .o_must_wait     (o_must_wait),
        .o_wake_one      (o_wake_one)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted command did not make the block busy.");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("Execute step lasted more than one cycle.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("Result strobe missing two cycles after a command transfer.");

    a_done_only_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("Result strobe without a preceding execute step.");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_created_id == '0 && !o_must_wait && !o_wake_one))
        else $error("Failed create carried non-zero result fields.");

endmodule

[sim/tb_counting_semaphore_table_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the counting semaphore table with a running predictor.
module tb_counting_semaphore_table_top;
    import cst_pkg::*;

    localparam int SEM_N        = 16;
    localparam int CREATE_SPAN  = (SEM_N < ID_SPAN) ? SEM_N : ID_SPAN;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic            status;
        logic [ID_W-1:0] created_id;
        logic            must_wait;
        logic            wake_one;
    } t_sem_result;

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             start           = 1'b0;
    logic [ACT_W-1:0] i_action        = ACT_CREATE;
    logic [ID_W-1:0]  i_entry_id      = '0;
    t_count           i_initial_count = '0;
    logic             busy;
    logic             o_done;
    logic             o_status;
    logic [ID_W-1:0]  o_created_id;
    logic             o_must_wait;
    logic             o_wake_one;

    logic        sem_alloc [SEM_N];
    t_count      sem_count [SEM_N];
    t_sem_result result_queue [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          idle_enable    = 1'b1;

    counting_semaphore_table_top #(
        .SEM_ENTRIES(SEM_N)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_entry_id     (i_entry_id),
        .i_initial_count(i_initial_count),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_created_id   (o_created_id),
        .o_must_wait    (o_must_wait),
        .o_wake_one     (o_wake_one)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_sem_result predict_semaphore(logic [ACT_W-1:0] act,
                                                      logic [ID_W-1:0] id, t_count init);
        t_sem_result res;
        bit          found;
        res        = '0;
        res.status = STATUS_DONE;
        found      = 1'b0;
        if (act == ACT_CREATE) begin
            for (int k = 0; k < CREATE_SPAN; k++) begin
                if (!found && !sem_alloc[k]) begin
                    sem_alloc[k]   = 1'b1;
                    sem_count[k]   = init;
                    res.created_id = ID_W'(k);
                    found          = 1'b1;
                end
            end
            if (!found) begin
                res.status = STATUS_NO_FREE;
            end
        end else if (int'(id) < SEM_N) begin
            case (act)
                ACT_FREE: begin
                    if (sem_alloc[id] && sem_count[id] > 0) begin
                        sem_alloc[id] = 1'b0;
                    end
                end
                ACT_P: begin
                    if (sem_count[id] != COUNT_MIN) begin
                        sem_count[id] = sem_count[id] - 16'sd1;
                    end
                    res.must_wait = (sem_count[id] < 0);
                end
                default: begin
                    if (sem_count[id] != COUNT_MAX) begin
                        sem_count[id] = sem_count[id] + 16'sd1;
                    end
                    res.wake_one = (sem_count[id] < 1);
                end
            endcase
        end
        return res;
    endfunction

    function automatic logic [ID_W-1:0] pick_entry();
        int live [$];
        for (int k = 0; k < SEM_N; k++) begin
            if (sem_alloc[k]) begin
                live.push_back(k);
            end
        end
        if (live.size() != 0 && $urandom_range(9) < 7) begin
            return ID_W'(live[$urandom_range(live.size() - 1)]);
        end
        return ID_W'($urandom_range(ID_SPAN - 1));
    endfunction

    function automatic t_count pick_count();
        case ($urandom_range(19))
            0:       return COUNT_MAX;
            1, 2:    return t_count'($urandom_range(32767, 1));
            default: return t_count'(int'($urandom_range(7)) - 2);
        endcase
    endfunction

    function automatic int free_slots();
        int n;
        n = 0;
        for (int k = 0; k < CREATE_SPAN; k++) begin
            if (!sem_alloc[k]) begin
                n++;
            end
        end
        return n;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("[%0t] MISMATCH on %s: got %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic send_command(logic [ACT_W-1:0] act, logic [ID_W-1:0] id, t_count init);
        start           <= 1'b1;
        i_action        <= act;
        i_entry_id      <= id;
        i_initial_count <= init;
        do begin
            @(posedge i_clk);
        end while (busy);
        result_queue.push_back(predict_semaphore(act, id, init));
    endtask

    task automatic sender_gap();
        if (idle_enable && $urandom_range(3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    task automatic issue(logic [ACT_W-1:0] act, logic [ID_W-1:0] id, t_count init);
        send_command(act, id, init);
        sender_gap();
    endtask

    task automatic test_unallocated_entries();
        issue(ACT_P, 4'd5, COUNT_MAX);
        issue(ACT_V, 4'd5, COUNT_MIN);
        issue(ACT_FREE, 4'd5, '0);
        issue(ACT_V, 4'd15, '0);
    endtask

    task automatic test_count_limits();
        issue(ACT_CREATE, 4'd15, COUNT_MAX);
        issue(ACT_V, 4'd0, '0);
        issue(ACT_CREATE, 4'd0, COUNT_MIN);
        issue(ACT_P, 4'd1, '0);
        issue(ACT_FREE, 4'd1, '0);
    endtask

    task automatic test_free_rules();
        issue(ACT_CREATE, 4'd9, t_count'(0));
        issue(ACT_FREE, 4'd2, '0);
        issue(ACT_CREATE, 4'd6, t_count'(1));
        issue(ACT_FREE, 4'd3, '0);
        issue(ACT_CREATE, 4'd3, t_count'(-1));
        issue(ACT_FREE, 4'd0, '0);
    endtask

    task automatic test_table_full();
        while (free_slots() != 0) begin
            issue(ACT_CREATE, pick_entry(), pick_count());
        end
        issue(ACT_CREATE, 4'd10, t_count'(16'h5A5A));
    endtask

    task automatic test_random(int n_items, bit with_gaps);
        logic [ACT_W-1:0] act;
        int               roll;
        idle_enable = with_gaps;
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(19);
            if (roll < 4) begin
                act = ACT_CREATE;
            end else if (roll < 8) begin
                act = ACT_FREE;
            end else if (roll < 14) begin
                act = ACT_P;
            end else begin
                act = ACT_V;
            end
            issue(act, pick_entry(), pick_count());
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_sem_result want;
        if (i_rst_n && o_done) begin
            if (result_queue.size() == 0) begin
                report_mismatch("unexpected result transfer", 1, 0);
            end else begin
                want = result_queue.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch("status", o_status, want.status);
                end
                if (o_created_id !== want.created_id) begin
                    report_mismatch("created_id", o_created_id, want.created_id);
                end
                if (o_must_wait !== want.must_wait) begin
                    report_mismatch("must_wait", o_must_wait, want.must_wait);
                end
                if (o_wake_one !== want.wake_one) begin
                    report_mismatch("wake_one", o_wake_one, want.wake_one);
                end
            end
        end
    end

    initial begin
        for (int k = 0; k < SEM_N; k++) begin
            sem_alloc[k] = 1'b0;
            sem_count[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unallocated_entries();
        test_count_limits();
        test_free_rules();
        test_table_full();
        test_random(1550, 1'b1);
        test_random(200, 1'b0);

        start <= 1'b0;
        while (result_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
